// ===== src/ghbl_pkg.sv =====
`timescale 1ns / 1ps

package ghbl_pkg;

   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;
   localparam int STEP_X_DEF   = 64;
   localparam int STEP_Y_DEF   = 64;

   localparam int HEIGHT_WRAP = 270;
   localparam int RAW_MAX     = 120;
   localparam int RAW_SCALE   = 3;
   localparam int FRAC_BITS   = 16;

   localparam int COUNT_RESET = 64;
   localparam int COUNT_MIN   = 2;

   localparam int CSR_DATA_W = 7;
   localparam int CELL_W     = 9;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [0:0] {
      CSR_COLS = 1'b0,
      CSR_ROWS = 1'b1
   } csr_addr_type;

   // grid size register as used: held in 2..hi
   function automatic logic [8:0] clamp_count(logic [CSR_DATA_W-1:0] v, logic [8:0] hi);
      logic [8:0] c;
      c = 9'(v);
      if (c < 9'(COUNT_MIN)) c = 9'(COUNT_MIN);
      if (c > hi) c = hi;
      return c;
   endfunction

endpackage

// ===== src/ghbl_ram.sv =====
`timescale 1ns / 1ps

module ghbl_ram
   import ghbl_pkg::*;
#(
   parameter int WIDTH = CELL_W,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/grid_height_bilinear_lookup.sv =====
`timescale 1ns / 1ps

// Height grid with bilinear lookup. Takes one item per clock while rsp is not stalled;
// each item passes through six register stages (wrap, divide, index, grid read,
// column blend, row blend) before its result appears on rsp. A stall on rsp holds
// each full stage with no empty stage ahead of it in the same cycle while the others
// keep moving, so req_ready drops only once all six stages hold items. Both writes and
// queries go through the same grid-access stage in order, so a query always sees every
// earlier write. The grid lives in four synchronous RAMs of 9-bit cells: rows are
// split into even and odd banks, and each bank is kept twice so that both columns of
// a query are read in the same cycle. Cells come up undefined and must be written
// before a query touches them; there is no clearing pass.
module grid_height_bilinear_lookup
   import ghbl_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int STEP_X   = STEP_X_DEF,
   parameter int STEP_Y   = STEP_Y_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic [5:0]              req_row_index,
   input  logic [5:0]              req_col_index,
   input  logic [7:0]              req_raw_height,
   input  logic signed [13:0]      req_x_pos,
   input  logic signed [13:0]      req_y_pos,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [8:0]              rsp_height,
   output logic                    rsp_bad_value,

   input  logic                    csr_we,
   input  logic [0:0]              csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW         = $clog2(MAX_COLS);
   localparam int RW         = $clog2(MAX_ROWS);
   localparam int HR_W       = (RW > 1) ? RW - 1 : 1;
   localparam int BANK_DEPTH = ((MAX_ROWS + 1) / 2) * (2 ** CW);
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   localparam int WXW  = $clog2(STEP_X * MAX_COLS + 1);
   localparam int WYW  = $clog2(STEP_Y * MAX_ROWS + 1);
   localparam int XS_W = ((WXW > 14) ? WXW : 14) + 2;
   localparam int YS_W = ((WYW > 14) ? WYW : 14) + 2;

   // division by the step: multiply by a rounded-up reciprocal, exact below 2**NX
   localparam int NX  = $clog2(STEP_X * MAX_COLS);
   localparam int NY  = $clog2(STEP_Y * MAX_ROWS);
   localparam int SHX = NX + $clog2(STEP_X);
   localparam int SHY = NY + $clog2(STEP_Y);
   localparam logic [NX+1:0] MULX = (NX+2)'(((2 ** SHX) + STEP_X - 1) / STEP_X);
   localparam logic [NY+1:0] MULY = (NY+2)'(((2 ** SHY) + STEP_Y - 1) / STEP_Y);

   localparam int UXW    = $clog2(STEP_X + 1);
   localparam int UYW    = $clog2(STEP_Y + 1);
   localparam int FW     = FRAC_BITS + 1;
   localparam int FRAC_X = (2 ** FRAC_BITS) / STEP_X;
   localparam int FRAC_Y = (2 ** FRAC_BITS) / STEP_Y;

   localparam int RST_NCOL = (COUNT_RESET > MAX_COLS) ? MAX_COLS : COUNT_RESET;
   localparam int RST_NROW = (COUNT_RESET > MAX_ROWS) ? MAX_ROWS : COUNT_RESET;

   typedef enum logic [1:0] {
      X_ZERO,
      X_EDGE,
      X_INSIDE
   } xmode_type;

   typedef enum logic [1:0] {
      Y_LAST,
      Y_FIRST,
      Y_INSIDE
   } ymode_type;

   function automatic logic [BANK_AW-1:0] bank_addr(logic [8:0] row, logic [CW-1:0] col);
      logic [HR_W-1:0] half;
      half = row[HR_W:1];
      return BANK_AW'({half, col});
   endfunction

   // a + floor((b - a) * f / 2**16)
   function automatic logic [CELL_W-1:0] blend(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b,
                                                logic [FW-1:0] f);
      logic signed [CELL_W:0]      diff;
      logic signed [CELL_W+FW+1:0] prod;
      logic signed [CELL_W+1:0]    step;
      logic signed [CELL_W+1:0]    sum;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = diff * $signed({1'b0, f});
      step = (CELL_W+2)'(prod >>> FRAC_BITS);
      sum  = $signed({2'b0, a}) + step;
      return sum[CELL_W-1:0];
   endfunction

   // ---------------- configuration ----------------
   logic [CW-1:0]  sx_ff, sx_in;
   logic [RW-1:0]  sy_ff, sy_in;
   logic [WXW-1:0] width_ff, width_in, limx_ff, limx_in;
   logic [WYW-1:0] limy_ff, limy_in;
   logic [8:0]     ncol_new, nrow_new;

   always_comb begin
      ncol_new = clamp_count(csr_wdata, 9'(MAX_COLS));
      nrow_new = clamp_count(csr_wdata, 9'(MAX_ROWS));
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      width_in = width_ff;
      limx_in  = limx_ff;
      limy_in  = limy_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_COLS: begin
               sx_in    = CW'(ncol_new - 9'd1);
               width_in = WXW'(ncol_new * STEP_X);
               limx_in  = WXW'((ncol_new - 9'd1) * STEP_X);
            end
            CSR_ROWS: begin
               sy_in   = RW'(nrow_new - 9'd1);
               limy_in = WYW'((nrow_new - 9'd1) * STEP_Y);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff    <= CW'(RST_NCOL - 1);
         sy_ff    <= RW'(RST_NROW - 1);
         width_ff <= WXW'(RST_NCOL * STEP_X);
         limx_ff  <= WXW'((RST_NCOL - 1) * STEP_X);
         limy_ff  <= WYW'((RST_NROW - 1) * STEP_Y);
      end else begin
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         width_ff <= width_in;
         limx_ff  <= limx_in;
         limy_ff  <= limy_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic en1, en2, en3, en4, en5, eno;

   assign eno       = !vo_ff || rsp_ready;
   assign en5       = !v5_ff || eno;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (eno) vo_ff <= v5_ff;
      end
   end

   // ---------------- stage 1: x wrap ----------------
   logic signed [XS_W-1:0] width_s, x_raw, x_wrap_in;

   always_comb begin
      width_s   = $signed(XS_W'(width_ff));
      x_raw     = XS_W'(req_x_pos);
      x_wrap_in = x_raw;
      if (x_wrap_in > width_s) x_wrap_in = x_wrap_in - width_s;
      if (x_wrap_in < 0) x_wrap_in = x_wrap_in + width_s;
   end

   logic                   func1_ff;
   logic [5:0]             row1_ff, col1_ff;
   logic [7:0]             raw1_ff;
   logic signed [XS_W-1:0] x1_ff;
   logic signed [13:0]     y1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         func1_ff <= req_func;
         row1_ff  <= req_row_index;
         col1_ff  <= req_col_index;
         raw1_ff  <= req_raw_height;
         x1_ff    <= x_wrap_in;
         y1_ff    <= req_y_pos;
      end
   end

   // ---------------- stage 2: regions and quotients ----------------
   logic signed [XS_W-1:0] limx_s, dx_full;
   logic signed [YS_W-1:0] limy_s, y_ext;
   logic [NX-1:0]          xu_in;
   logic [NY-1:0]          yu_in;
   logic [2*NX+1:0]        prod_x;
   logic [2*NY+1:0]        prod_y;
   logic [CW-1:0]          qx_in;
   logic [RW-1:0]          qy_in;
   logic [UXW-1:0]         dxs_in;
   xmode_type              xmode_in;
   ymode_type              ymode_in;

   always_comb begin
      limx_s = $signed(XS_W'(limx_ff));
      limy_s = $signed(YS_W'(limy_ff));
      y_ext  = YS_W'(y1_ff);

      if (x1_ff <= 0) xmode_in = X_ZERO;
      else if (x1_ff >= limx_s) xmode_in = X_EDGE;
      else xmode_in = X_INSIDE;

      if (y_ext <= 0) ymode_in = Y_LAST;
      else if (y_ext >= limy_s) ymode_in = Y_FIRST;
      else ymode_in = Y_INSIDE;

      // past the last column the offset saturates at one step
      dx_full = x1_ff - limx_s;
      if (dx_full > XS_W'(STEP_X)) dxs_in = UXW'(STEP_X);
      else dxs_in = UXW'(dx_full);

      xu_in  = NX'(x1_ff);
      yu_in  = NY'(y1_ff[12:0]);
      prod_x = (2*NX+2)'(xu_in) * (2*NX+2)'(MULX);
      prod_y = (2*NY+2)'(yu_in) * (2*NY+2)'(MULY);
      qx_in  = prod_x[SHX +: CW];
      qy_in  = prod_y[SHY +: RW];
   end

   logic           func2_ff;
   logic [5:0]     row2_ff, col2_ff;
   logic [7:0]     raw2_ff;
   xmode_type      xmode2_ff;
   ymode_type      ymode2_ff;
   logic [NX-1:0]  xu2_ff;
   logic [NY-1:0]  yu2_ff;
   logic [CW-1:0]  qx2_ff;
   logic [RW-1:0]  qy2_ff;
   logic [UXW-1:0] dxs2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         func2_ff  <= func1_ff;
         row2_ff   <= row1_ff;
         col2_ff   <= col1_ff;
         raw2_ff   <= raw1_ff;
         xmode2_ff <= xmode_in;
         ymode2_ff <= ymode_in;
         xu2_ff    <= xu_in;
         yu2_ff    <= yu_in;
         qx2_ff    <= qx_in;
         qy2_ff    <= qy_in;
         dxs2_ff   <= dxs_in;
      end
   end

   // ---------------- stage 3: cell indices ----------------
   logic [NX-1:0]  rx_full;
   logic [NY-1:0]  ry_full;
   logic [UXW-1:0] ux_in;
   logic [UYW-1:0] uy_in;
   logic [CW-1:0]  ca_in, cb_in;
   logic [RW-1:0]  ya_in, yb_in;
   logic           single_in;

   always_comb begin
      rx_full = xu2_ff - NX'(qx2_ff * STEP_X);
      ry_full = yu2_ff - NY'(qy2_ff * STEP_Y);

      unique case (xmode2_ff)
         X_ZERO: begin
            ca_in = '0;
            cb_in = '0;
            ux_in = '0;
         end
         X_EDGE: begin
            ca_in = sx_ff;
            cb_in = '0;
            ux_in = dxs2_ff;
         end
         X_INSIDE: begin
            ca_in = qx2_ff;
            cb_in = qx2_ff + CW'(1);
            ux_in = UXW'(rx_full);
         end
         default: begin
            ca_in = '0;
            cb_in = '0;
            ux_in = '0;
         end
      endcase

      // rows run opposite to load order
      unique case (ymode2_ff)
         Y_LAST: begin
            ya_in     = sy_ff;
            yb_in     = sy_ff;
            uy_in     = '0;
            single_in = 1'b1;
         end
         Y_FIRST: begin
            ya_in     = '0;
            yb_in     = '0;
            uy_in     = '0;
            single_in = 1'b1;
         end
         Y_INSIDE: begin
            ya_in     = sy_ff - qy2_ff - RW'(1);
            yb_in     = sy_ff - qy2_ff;
            uy_in     = UYW'(ry_full);
            single_in = 1'b0;
         end
         default: begin
            ya_in     = '0;
            yb_in     = '0;
            uy_in     = '0;
            single_in = 1'b1;
         end
      endcase
   end

   logic           func3_ff;
   logic [5:0]     row3_ff, col3_ff;
   logic [7:0]     raw3_ff;
   logic [CW-1:0]  ca3_ff, cb3_ff;
   logic [RW-1:0]  ya3_ff, yb3_ff;
   logic           single3_ff;
   logic [UXW-1:0] ux3_ff;
   logic [UYW-1:0] uy3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         func3_ff   <= func2_ff;
         row3_ff    <= row2_ff;
         col3_ff    <= col2_ff;
         raw3_ff    <= raw2_ff;
         ca3_ff     <= ca_in;
         cb3_ff     <= cb_in;
         ya3_ff     <= ya_in;
         yb3_ff     <= yb_in;
         single3_ff <= single_in;
         ux3_ff     <= ux_in;
         uy3_ff     <= uy_in;
      end
   end

   // ---------------- grid access: writes and reads in item order ----------------
   logic               wr_ok, wr_en, rd_en, bad_in;
   logic [BANK_AW-1:0] wr_addr;
   logic [CELL_W-1:0]  wr_data;
   logic [RW-1:0]      row_even, row_odd;
   logic [BANK_AW-1:0] rd_addr [2][2];
   logic [CELL_W-1:0]  rd_data [2][2];
   logic [FW-1:0]      fx_in, fy_in;

   always_comb begin
      bad_in  = raw3_ff > 8'(RAW_MAX);
      wr_ok   = !bad_in && ({3'b0, row3_ff} < 9'(MAX_ROWS)) && ({3'b0, col3_ff} < 9'(MAX_COLS));
      wr_en   = en4 && v3_ff && (func3_ff == FUNC_WRITE) && wr_ok;
      rd_en   = en4 && v3_ff && (func3_ff == FUNC_QUERY);
      wr_addr = bank_addr({3'b0, row3_ff}, CW'(col3_ff));
      wr_data = CELL_W'(raw3_ff * RAW_SCALE);

      // the two rows of a two-row query always differ in parity
      row_even      = ya3_ff[0] ? yb3_ff : ya3_ff;
      row_odd       = ya3_ff[0] ? ya3_ff : yb3_ff;
      rd_addr[0][0] = bank_addr(9'(row_even), ca3_ff);
      rd_addr[0][1] = bank_addr(9'(row_even), cb3_ff);
      rd_addr[1][0] = bank_addr(9'(row_odd), ca3_ff);
      rd_addr[1][1] = bank_addr(9'(row_odd), cb3_ff);

      fx_in = FW'(ux3_ff * FRAC_X);
      fy_in = FW'(uy3_ff * FRAC_Y);
   end

   for (genvar bank = 0; bank < 2; bank++) begin : g_bank
      for (genvar copy = 0; copy < 2; copy++) begin : g_copy
         ghbl_ram #(
            .WIDTH (CELL_W),
            .DEPTH (BANK_DEPTH)
         ) u_ram (
            .clock   (clock),
            .wr_en   (wr_en && (row3_ff[0] == 1'(bank))),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (rd_en),
            .rd_addr (rd_addr[bank][copy]),
            .rd_data (rd_data[bank][copy])
         );
      end
   end

   logic          func4_ff, bad4_ff, single4_ff, ya_odd4_ff;
   logic [FW-1:0] fx4_ff, fy4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         func4_ff   <= func3_ff;
         bad4_ff    <= bad_in;
         single4_ff <= single3_ff;
         ya_odd4_ff <= ya3_ff[0];
         fx4_ff     <= fx_in;
         fy4_ff     <= fy_in;
      end
   end

   // ---------------- stage 5: blend along x ----------------
   logic [CELL_W-1:0] top_a, top_b, bot_a, bot_b, ha_in, hb_in;

   always_comb begin
      top_a = rd_data[ya_odd4_ff][0];
      top_b = rd_data[ya_odd4_ff][1];
      bot_a = rd_data[!ya_odd4_ff][0];
      bot_b = rd_data[!ya_odd4_ff][1];
      ha_in = blend(top_a, top_b, fx4_ff);
      hb_in = blend(bot_a, bot_b, fx4_ff);
   end

   logic              func5_ff, bad5_ff, single5_ff;
   logic [CELL_W-1:0] ha5_ff, hb5_ff;
   logic [FW-1:0]     fy5_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         func5_ff   <= func4_ff;
         bad5_ff    <= bad4_ff;
         single5_ff <= single4_ff;
         ha5_ff     <= ha_in;
         hb5_ff     <= hb_in;
         fy5_ff     <= fy4_ff;
      end
   end

   // ---------------- output: blend along y, wrap ----------------
   logic [CELL_W-1:0] hv, hwrap, height_in;
   logic              bad_value_in;

   always_comb begin
      hv           = single5_ff ? ha5_ff : blend(hb5_ff, ha5_ff, fy5_ff);
      hwrap        = (hv >= CELL_W'(HEIGHT_WRAP)) ? hv - CELL_W'(HEIGHT_WRAP) : hv;
      height_in    = (func5_ff == FUNC_QUERY) ? hwrap : '0;
      bad_value_in = (func5_ff == FUNC_WRITE) && bad5_ff;
   end

   logic [8:0] rsp_height_ff;
   logic       rsp_bad_value_ff;

   always_ff @(posedge clock) begin
      if (eno) begin
         rsp_height_ff    <= height_in;
         rsp_bad_value_ff <= bad_value_in;
      end
   end

   assign rsp_valid     = vo_ff;
   assign rsp_height    = rsp_height_ff;
   assign rsp_bad_value = rsp_bad_value_ff;

`ifndef SYNTH
   a_no_bad_store: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (raw3_ff <= 8'(RAW_MAX)))
      else $error("out-of-range raw value stored");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("grid read and write in the same cycle");

   a_row_parity: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !single3_ff) |-> (ya3_ff[0] != yb3_ff[0]))
      else $error("two query rows in the same bank");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_height < 9'(HEIGHT_WRAP)))
      else $error("height not wrapped");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_value) |-> (rsp_height == 9'd0))
      else $error("write item with nonzero height");
`endif

endmodule
